// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LTC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ltc_pkg.sv
// Shared types, codes and helpers for the link training controller.
// No dependencies.
package ltc_pkg;

    localparam int CMD_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TPS3        = 3'd0,
        CFG_MAX_SWING   = 3'd1,
        CFG_START_LANES = 3'd2,
        CFG_SAME_LIMIT  = 3'd3,
        CFG_EQ_TRIES    = 3'd4,
        CFG_STEP_LIMIT  = 3'd5
    } t_cfg_idx;

    localparam logic REQ_START = 1'b0;

    localparam logic [1:0] ST_TRAINING = 2'd0;
    localparam logic [1:0] ST_SUCCESS  = 2'd1;
    localparam logic [1:0] ST_FAILURE  = 2'd2;
    localparam logic [1:0] ST_TIMEOUT  = 2'd3;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_CR   = 2'd1;
    localparam logic [1:0] PHASE_EQ   = 2'd2;

    localparam logic [1:0] PAT_OFF  = 2'd0;
    localparam logic [1:0] PAT_TPS1 = 2'd1;
    localparam logic [1:0] PAT_TPS2 = 2'd2;
    localparam logic [1:0] PAT_TPS3 = 2'd3;

    localparam logic [1:0] RATE_162 = 2'd0;
    localparam logic [1:0] RATE_270 = 2'd1;
    localparam logic [1:0] RATE_540 = 2'd2;

    localparam logic [2:0] SWING_NONE = 3'd7;
    localparam logic [2:0] LANES_MIN  = 3'd1;
    localparam logic [2:0] LANES_MAX  = 3'd4;

    typedef struct packed {
        logic       tps3;
        logic [1:0] max_swing;
        logic [2:0] start_lanes;
        logic [3:0] same_limit;
        logic [3:0] eq_tries;
        logic [7:0] step_limit;
    } t_cfg;

    typedef struct packed {
        logic       is_start;
        logic       cr_done;
        logic       eq_done;
        logic [1:0] swing;
        logic [1:0] preemph;
        logic       link_ok;
    } t_cmd;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] phase;
        logic [1:0] pattern;
        logic       scramble_off;
        logic [1:0] link_rate;
        logic [2:0] lane_count;
        logic [1:0] drive_swing;
        logic [1:0] drive_preemph;
    } t_result;

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

// File: rtl/core/link_training_controller.sv
// Link training controller, top level: config registers, front and back ends.
// Throughput: one item per cycle unless the command or result queue is full.
// An accepted item is written to the command queue; the back end then takes it,
// updates its state and writes the result queue; the result ports show its head.
// Reset: synchronous, active low; clears state and queues.
// Depends on ltc_pkg, ltc_front, ltc_back.
module link_training_controller import ltc_pkg::*; #(
    parameter int CMD_DEPTH = CMD_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_req_type,
    input  logic                  i_cr_done,
    input  logic                  i_eq_done,
    input  logic [1:0]            i_requested_swing,
    input  logic [1:0]            i_requested_preemph,
    input  logic                  i_link_ok,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_status,
    output logic [1:0]            o_phase,
    output logic [1:0]            o_pattern,
    output logic                  o_scramble_off,
    output logic [1:0]            o_link_rate,
    output logic [2:0]            o_lane_count,
    output logic [1:0]            o_drive_swing,
    output logic [1:0]            o_drive_preemph
);
    t_cfg    r_cfg;
    logic    cmd_valid, cmd_pop;
    t_cmd    cmd;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tps3        <= 1'b0;
            r_cfg.max_swing   <= 2'd3;
            r_cfg.start_lanes <= 3'd2;
            r_cfg.same_limit  <= 4'd5;
            r_cfg.eq_tries    <= 4'd5;
            r_cfg.step_limit  <= 8'd100;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TPS3:        r_cfg.tps3        <= i_cfg_data[0];
                CFG_MAX_SWING:   r_cfg.max_swing   <= i_cfg_data[1:0];
                CFG_START_LANES: r_cfg.start_lanes <= i_cfg_data[2:0];
                CFG_SAME_LIMIT:  r_cfg.same_limit  <= i_cfg_data[3:0];
                CFG_EQ_TRIES:    r_cfg.eq_tries    <= i_cfg_data[3:0];
                CFG_STEP_LIMIT:  r_cfg.step_limit  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    ltc_front #(.DEPTH(CMD_DEPTH)) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_req_type          (i_req_type),
        .i_cr_done           (i_cr_done),
        .i_eq_done           (i_eq_done),
        .i_requested_swing   (i_requested_swing),
        .i_requested_preemph (i_requested_preemph),
        .i_link_ok           (i_link_ok),
        .o_cmd_valid         (cmd_valid),
        .o_cmd               (cmd),
        .i_cmd_pop           (cmd_pop)
    );

    ltc_back #(.DEPTH(OUT_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result)
    );

    assign o_status        = result.status;
    assign o_phase         = result.phase;
    assign o_pattern       = result.pattern;
    assign o_scramble_off  = result.scramble_off;
    assign o_link_rate     = result.link_rate;
    assign o_lane_count    = result.lane_count;
    assign o_drive_swing   = result.drive_swing;
    assign o_drive_preemph = result.drive_preemph;

endmodule

// File: rtl/core/ltc_front.sv
// Front end: accepts items, decodes them into commands, queues them.
// Depends on ltc_pkg.
module ltc_front import ltc_pkg::*; #(
    parameter int DEPTH = CMD_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_req_type,
    input  logic       i_cr_done,
    input  logic       i_eq_done,
    input  logic [1:0] i_requested_swing,
    input  logic [1:0] i_requested_preemph,
    input  logic       i_link_ok,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_pop
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    t_cmd             w_cmd;
    logic             w_push, w_pop;

    always_comb begin
        w_cmd.is_start = (i_req_type == REQ_START);
        w_cmd.cr_done  = i_cr_done;
        w_cmd.eq_done  = i_eq_done;
        w_cmd.swing    = i_requested_swing;
        w_cmd.preemph  = i_requested_preemph;
        w_cmd.link_ok  = i_link_ok;
    end

    assign full        = (r_count == CNT_W'(DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(w_push) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

// File: rtl/core/ltc_back.sv
// Back end: training state machine, one command per cycle while the result queue has room, result queue.
// Depends on ltc_pkg.
module ltc_back import ltc_pkg::*; #(
    parameter int DEPTH = OUT_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = PHASE_IDLE,
        S_CR   = PHASE_CR,
        S_EQ   = PHASE_EQ
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [1:0] r_rate, n_rate;
    logic [2:0] r_lanes, n_lanes;
    logic [2:0] r_prev, n_prev;
    logic [3:0] r_same, n_same;
    logic [3:0] r_eq_left, n_eq_left;
    logic [7:0] r_steps, n_steps;
    logic [1:0] r_swing, n_swing;
    logic [1:0] r_preemph, n_preemph;
    logic [1:0] r_pat, n_pat;
    logic [1:0] r_outcome, n_outcome;

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic       w_take, w_out_full, w_pop;
    logic       do_fb, do_eq, do_cr;
    logic [7:0] s1, s2, s3;
    logic [3:0] same_nxt, eq_dec;
    t_result    w_result;

    assign w_out_full = (r_count == CNT_W'(DEPTH));
    assign w_take     = i_cmd_valid && !w_out_full;
    assign o_cmd_pop  = w_take;
    assign empty      = (r_count == '0);
    assign w_pop      = pop && !empty;
    assign o_result   = r_mem[r_rd_ptr];

    always_comb begin
        n_phase   = r_phase;
        n_rate    = r_rate;
        n_lanes   = r_lanes;
        n_prev    = r_prev;
        n_same    = r_same;
        n_eq_left = r_eq_left;
        n_steps   = r_steps;
        n_swing   = r_swing;
        n_preemph = r_preemph;
        n_pat     = r_pat;
        n_outcome = r_outcome;
        do_fb     = 1'b0;
        do_eq     = 1'b0;
        do_cr     = 1'b0;
        same_nxt  = r_same;
        s1        = sat_inc8(r_steps);
        s2        = sat_inc8(s1);
        s3        = sat_inc8(s2);
        eq_dec    = r_eq_left - 4'(r_eq_left != '0);

        if (i_cmd.is_start) begin
            if (i_cfg.start_lanes < LANES_MIN) begin
                n_lanes = LANES_MIN;
            end else if (i_cfg.start_lanes > LANES_MAX) begin
                n_lanes = LANES_MAX;
            end else begin
                n_lanes = i_cfg.start_lanes;
            end
            n_rate    = RATE_540;
            n_steps   = '0;
            n_outcome = ST_TRAINING;
            do_cr     = 1'b1;
        end else if (r_phase == S_CR) begin
            n_swing   = i_cmd.swing;
            n_preemph = i_cmd.preemph;
            if (i_cmd.cr_done) begin
                do_eq = 1'b1;
            end else begin
                if (r_prev == {1'b0, i_cmd.swing}) begin
                    same_nxt = (r_same == 4'hF) ? r_same : r_same + 4'd1;
                end else begin
                    same_nxt = '0;
                    n_prev   = {1'b0, i_cmd.swing};
                end
                n_same = same_nxt;
                if (same_nxt >= i_cfg.same_limit || i_cmd.swing == i_cfg.max_swing) begin
                    do_fb = 1'b1;
                end
            end
        end else if (r_phase == S_EQ) begin
            n_swing   = i_cmd.swing;
            n_preemph = i_cmd.preemph;
            if (!i_cmd.cr_done) begin
                do_fb = 1'b1;
            end else if (i_cmd.eq_done) begin
                n_phase = S_IDLE;
                if (i_cmd.link_ok) begin
                    n_pat     = PAT_OFF;
                    n_outcome = ST_SUCCESS;
                end else begin
                    n_outcome = ST_FAILURE;
                end
            end else begin
                n_eq_left = eq_dec;
                if (eq_dec == '0) begin
                    do_fb = 1'b1;
                end
            end
        end

        if (do_eq) begin
            n_steps = s1;
            if (s1 >= i_cfg.step_limit) begin
                n_phase   = S_IDLE;
                n_outcome = ST_TIMEOUT;
            end else begin
                n_phase   = S_EQ;
                n_pat     = i_cfg.tps3 ? PAT_TPS3 : PAT_TPS2;
                n_eq_left = (i_cfg.eq_tries != '0) ? i_cfg.eq_tries : 4'd1;
            end
        end

        // Each leg of the fallback counts transitions and may time out midway.
        if (do_fb) begin
            n_steps = s1;
            if (s1 >= i_cfg.step_limit) begin
                n_phase   = S_IDLE;
                n_outcome = ST_TIMEOUT;
            end else if (r_rate == RATE_540 || r_rate == RATE_270) begin
                n_rate  = r_rate - 2'd1;
                n_steps = s2;
                if (s2 >= i_cfg.step_limit) begin
                    n_phase   = S_IDLE;
                    n_outcome = ST_TIMEOUT;
                end else begin
                    do_cr = 1'b1;
                end
            end else begin
                n_steps = s2;
                if (s2 >= i_cfg.step_limit) begin
                    n_phase   = S_IDLE;
                    n_outcome = ST_TIMEOUT;
                end else if (r_lanes <= LANES_MIN) begin
                    n_phase   = S_IDLE;
                    n_outcome = ST_FAILURE;
                end else begin
                    n_lanes = r_lanes - 3'd1;
                    n_rate  = RATE_540;
                    n_steps = s3;
                    if (s3 >= i_cfg.step_limit) begin
                        n_phase   = S_IDLE;
                        n_outcome = ST_TIMEOUT;
                    end else begin
                        do_cr = 1'b1;
                    end
                end
            end
        end

        if (do_cr) begin
            n_phase   = S_CR;
            n_swing   = '0;
            n_preemph = '0;
            n_prev    = SWING_NONE;
            n_same    = '0;
            n_pat     = PAT_TPS1;
        end

        w_result.status        = (n_phase != S_IDLE) ? ST_TRAINING : n_outcome;
        w_result.phase         = n_phase;
        w_result.pattern       = n_pat;
        w_result.scramble_off  = (n_pat != PAT_OFF);
        w_result.link_rate     = n_rate;
        w_result.lane_count    = n_lanes;
        w_result.drive_swing   = n_swing;
        w_result.drive_preemph = n_preemph;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_take) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + CNT_W'(w_take) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= S_IDLE;
            r_rate    <= RATE_540;
            r_lanes   <= 3'd2;
            r_prev    <= SWING_NONE;
            r_same    <= '0;
            r_eq_left <= '0;
            r_steps   <= '0;
            r_swing   <= '0;
            r_preemph <= '0;
            r_pat     <= PAT_OFF;
            r_outcome <= ST_TRAINING;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
        end else begin
            if (w_take) begin
                r_phase   <= n_phase;
                r_rate    <= n_rate;
                r_lanes   <= n_lanes;
                r_prev    <= n_prev;
                r_same    <= n_same;
                r_eq_left <= n_eq_left;
                r_steps   <= n_steps;
                r_swing   <= n_swing;
                r_preemph <= n_preemph;
                r_pat     <= n_pat;
                r_outcome <= n_outcome;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mem[r_wr_ptr] <= w_result;
        end
    end

endmodule

// File: rtl/core/ltc_checker.sv
// Port-level checker for the link training controller, bound to the top level.
// Depends on ltc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ltc_checker import ltc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_status,
    input logic [1:0] o_phase,
    input logic [1:0] o_pattern,
    input logic       o_scramble_off,
    input logic [1:0] o_link_rate,
    input logic [2:0] o_lane_count,
    input logic [1:0] o_drive_swing
);

    // Scrambling is off exactly while a pattern is sent.
    `LTC_ASSERT_IMPLY(a_scramble, i_clk, i_rst_n, !empty,
        o_scramble_off == (o_pattern != PAT_OFF), "scramble_off disagrees with pattern")

    // A final status only appears once training has stopped.
    `LTC_ASSERT_IMPLY(a_done_idle, i_clk, i_rst_n, !empty && o_status != ST_TRAINING,
        o_phase == PHASE_IDLE, "final status while training")

    // Clock recovery always sends pattern 1 with a legal lane count.
    `LTC_ASSERT_IMPLY(a_cr_pat, i_clk, i_rst_n, !empty && o_phase == PHASE_CR,
        o_pattern == PAT_TPS1 && o_lane_count >= LANES_MIN && o_lane_count <= LANES_MAX,
        "bad clock recovery report")

    // A result not taken stays on the ports.
    `LTC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_status) && $stable(o_drive_swing) && $stable(o_link_rate),
        "waiting result changed")

endmodule

bind link_training_controller ltc_checker u_ltc_checker (.*);
